// ===== design/bia_pkg.sv =====
// Shared types, constants and register codes for the horizontal image alignment block.
package bia_pkg;

    localparam int BIA_MAX_COLS   = 64;
    localparam int BIA_MAX_ROWS   = 64;
    localparam int BIA_PIXEL_BITS = 16;

    localparam int PIX_W      = 16;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int DIM_W      = 7;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int RESET_DIM  = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ALIGN_MODE = 2'd0;
    localparam t_reg_idx REG_IMAGE_COLS = 2'd1;
    localparam t_reg_idx REG_IMAGE_ROWS = 2'd2;

    localparam logic OP_LOAD        = 1'b0;
    localparam logic OP_FETCH       = 1'b1;
    localparam logic MODE_ORIGIN    = 1'b0;
    localparam logic MODE_CENTER    = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD_DIV,
        S_CENT_DIV,
        S_DRAIN_DIV,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/bia_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module bia_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 14
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_W-1:0]    i_dividend,
    input  logic [DIVISOR_W-1:0]     i_divisor,
    output bia_pkg::t_div_stat       o_stat,
    output logic [DIVIDEND_W-1:0]    o_quotient,
    output logic [DIVISOR_W-1:0]     o_remainder
);
    import bia_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fit;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
        w_diff  = w_trial - {1'b0, r_divisor};
        w_fit   = (w_trial >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one dividend bit, subtract the divisor when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/binary_image_horizontal_align.sv =====
// Load: each pixel takes one division on the shared divider, D = IDX_W+CNT_C_W+2 quotient bits
// (22 at 64x64). Fetch: CHECK, DRAIN_DIV, READ and EMIT, then the output register; a new item
// is taken only after the result has entered that register. The first fetch of a frame in center
// mode adds the centroid division. Refused fetch: CHECK and EMIT, then the output register.
// Synchronous active-low reset clears control, configuration, counters and trackers; datapath
// registers and the frame memory are not cleared, and the memory needs no clearing pass.
module binary_image_horizontal_align #(
    parameter int MAX_COLS   = bia_pkg::BIA_MAX_COLS,
    parameter int MAX_ROWS   = bia_pkg::BIA_MAX_ROWS,
    parameter int PIXEL_BITS = bia_pkg::BIA_PIXEL_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bia_pkg::S_DATA_W-1:0]   i_s_tdata,   // [15:0] pixel_value
    input  logic                           i_s_tuser,   // [0] op
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bia_pkg::M_DATA_W-1:0]   o_m_tdata,   // [15:0] pixel_out, [21:16] out_row,
                                                        // [27:22] out_col, [31:28] zero
    output logic                           o_m_tlast,   // last_pixel
    output logic                           o_m_tuser,   // [0] status
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bia_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bia_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bia_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bia_pkg::*;

    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W    = $clog2(DEPTH + 1);
    localparam int CNT_C_W  = $clog2(MAX_COLS + 1);
    localparam int CNT_R_W  = $clog2(MAX_ROWS + 1);
    localparam int SUM_W    = IDX_W + CNT_C_W;
    localparam int DIV_W    = SUM_W + 2;
    localparam int DVS_W    = IDX_W + 1;
    localparam int SH_W     = CNT_C_W + 1;
    localparam int SRC_W    = CNT_C_W + 2;
    localparam int ASUM_W   = IDX_W + 2;
    localparam int RST_COLS = (RESET_DIM > MAX_COLS) ? MAX_COLS : RESET_DIM;

    // configuration registers
    logic             r_mode;
    logic [DIM_W-1:0] r_cols;
    logic [DIM_W-1:0] r_rows;

    // frame state
    t_state               r_state;
    t_state               n_state;
    logic                 r_op;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [IDX_W-1:0]     r_total;
    logic [IDX_W-1:0]     r_load_count;
    logic [IDX_W-1:0]     r_drain_count;
    logic [IDX_W-1:0]     r_set_count;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_C_W-1:0]   r_leftmost;
    logic signed [SH_W-1:0] r_shift;

    // drain staging
    logic                 r_inrange;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic                 r_last;
    logic [PIXEL_BITS-1:0] r_rd_data;
    logic [PIXEL_BITS-1:0] r_frame [DEPTH];

    // pending result and output register
    logic [PIX_W-1:0]     r_res_pix;
    logic [ROW_W-1:0]     r_res_row;
    logic [COL_W-1:0]     r_res_col;
    logic                 r_res_last;
    logic                 r_res_status;
    logic                 r_out_valid;
    logic [M_DATA_W-1:0]  r_out_data;
    logic                 r_out_last;
    logic                 r_out_user;

    // combinational
    logic [CNT_C_W-1:0]   w_cols;
    logic [CNT_R_W-1:0]   w_rows;
    logic                 w_cfg_wr;
    logic                 w_in_xfer;
    logic                 w_out_free;
    logic                 w_loaded;
    logic                 w_need_cent;
    logic                 w_div_start;
    logic [DIV_W-1:0]     w_div_dividend;
    logic [DVS_W-1:0]     w_div_divisor;
    t_div_stat            w_div_stat;
    logic [DIV_W-1:0]     w_div_quo;
    logic [DVS_W-1:0]     w_div_rem;
    logic                 w_mem_we;
    logic [CNT_C_W-1:0]   w_rem_col;
    logic                 w_pix_set;
    logic [CNT_C_W-1:0]   w_left_base;
    logic signed [SRC_W-1:0]  w_src;
    logic signed [ASUM_W-1:0] w_addr_sum;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_src_ok;
    logic                 w_row_ok;
    logic                 w_drain_last;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ORIGIN;
            r_cols <= DIM_W'(RESET_DIM);
            r_rows <= DIM_W'(RESET_DIM);
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_ALIGN_MODE: r_mode <= pwdata[0];
                REG_IMAGE_COLS: r_cols <= pwdata[DIM_W-1:0];
                REG_IMAGE_ROWS: r_rows <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ALIGN_MODE: prdata = CFG_DATA_W'(r_mode);
            REG_IMAGE_COLS: prdata = CFG_DATA_W'(r_cols);
            REG_IMAGE_ROWS: prdata = CFG_DATA_W'(r_rows);
            default:        prdata = '0;
        endcase
    end

    // Clamp geometry to 1..MAX
    always_comb begin
        if (r_cols == '0)
            w_cols = CNT_C_W'(1);
        else if (32'(r_cols) > 32'(MAX_COLS))
            w_cols = CNT_C_W'(MAX_COLS);
        else
            w_cols = CNT_C_W'(r_cols);
        if (r_rows == '0)
            w_rows = CNT_R_W'(1);
        else if (32'(r_rows) > 32'(MAX_ROWS))
            w_rows = CNT_R_W'(MAX_ROWS);
        else
            w_rows = CNT_R_W'(r_rows);
    end

    always_ff @(posedge i_clk) begin
        r_total <= IDX_W'(IDX_W'(w_cols) * IDX_W'(w_rows));
    end

    // ---------------------------------------------------------------- divider
    bia_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_stat      (w_div_stat),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // ---------------------------------------------------------------- control
    assign w_in_xfer   = i_s_tvalid & o_s_tready;
    assign w_out_free  = ~r_out_valid | i_m_tready;
    assign w_loaded    = (r_load_count >= r_total);
    assign w_need_cent = (r_drain_count == '0) && (r_mode == MODE_CENTER) &&
                         (r_set_count != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (w_in_xfer) n_state = S_CHECK;
            S_CHECK: begin
                if (r_op == OP_LOAD)
                    n_state = w_loaded ? S_IDLE : S_LOAD_DIV;
                else if (!w_loaded)
                    n_state = S_EMIT;
                else if (w_need_cent)
                    n_state = S_CENT_DIV;
                else
                    n_state = S_DRAIN_DIV;
            end
            S_LOAD_DIV:  if (w_div_stat.done) n_state = S_IDLE;
            S_CENT_DIV:  if (w_div_stat.done) n_state = S_DRAIN_DIV;
            S_DRAIN_DIV: if (w_div_stat.done) n_state = S_READ;
            S_READ:      n_state = S_EMIT;
            S_EMIT:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        w_div_start    = 1'b0;
        w_mem_we       = 1'b0;
        w_div_dividend = DIV_W'(r_drain_count);
        w_div_divisor  = DVS_W'(w_cols);
        unique case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_CHECK: begin
                if (r_op == OP_LOAD) begin
                    w_div_start    = ~w_loaded;
                    w_div_dividend = DIV_W'(r_load_count);
                end else if (w_loaded) begin
                    w_div_start = 1'b1;
                    if (w_need_cent) begin
                        // round half up: (2*sum + n) / (2*n)
                        w_div_dividend = DIV_W'({r_sum, 1'b0}) + DIV_W'(r_set_count);
                        w_div_divisor  = DVS_W'({r_set_count, 1'b0});
                    end
                end
            end
            S_LOAD_DIV: w_mem_we    = w_div_stat.done;
            S_CENT_DIV: w_div_start = w_div_stat.done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // ---------------------------------------------------------------- datapath
    assign w_rem_col   = CNT_C_W'(w_div_rem);
    assign w_pix_set   = ($signed(r_pix) > 0);
    assign w_left_base = (r_load_count == '0) ? w_cols : r_leftmost;

    assign w_src      = $signed({2'b00, w_rem_col}) + SRC_W'(r_shift);
    assign w_src_ok   = (w_src >= 0) && (w_src < $signed({2'b00, w_cols}));
    assign w_row_ok   = (w_div_quo < DIV_W'(w_rows));
    assign w_addr_sum = $signed({2'b00, r_drain_count}) + ASUM_W'(r_shift);
    assign w_rd_addr  = w_addr_sum[AW-1:0];
    assign w_drain_last = ((IDX_W+1)'(r_drain_count) + 1'b1 >= (IDX_W+1)'(r_total));

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op  <= i_s_tuser;
            r_pix <= PIXEL_BITS'($signed(i_s_tdata[PIX_W-1:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count  <= '0;
            r_drain_count <= '0;
            r_set_count   <= '0;
            r_sum         <= '0;
            r_shift       <= '0;
            r_leftmost    <= CNT_C_W'(RST_COLS);
        end else begin
            unique case (r_state)
                S_CHECK: begin
                    if (r_op == OP_FETCH && w_loaded && r_drain_count == '0 && !w_need_cent) begin
                        if (r_mode == MODE_ORIGIN)
                            r_shift <= $signed({1'b0, (r_set_count != '0) ? r_leftmost : w_cols});
                        else
                            r_shift <= -$signed({1'b0, w_cols >> 1});
                    end
                end
                S_LOAD_DIV: begin
                    if (w_div_stat.done) begin
                        r_leftmost <= (w_pix_set && w_rem_col < w_left_base) ?
                                      w_rem_col : w_left_base;
                        if (w_pix_set) begin
                            r_sum       <= r_sum + SUM_W'(w_rem_col);
                            r_set_count <= r_set_count + 1'b1;
                        end
                        r_load_count <= r_load_count + 1'b1;
                    end
                end
                S_CENT_DIV: begin
                    if (w_div_stat.done)
                        r_shift <= $signed({1'b0, CNT_C_W'(w_div_quo)}) -
                                   $signed({1'b0, w_cols >> 1});
                end
                S_READ: begin
                    // Clear the frame counters and trackers after its final pixel
                    if (r_last) begin
                        r_load_count  <= '0;
                        r_drain_count <= '0;
                        r_set_count   <= '0;
                        r_sum         <= '0;
                        r_shift       <= '0;
                        r_leftmost    <= w_cols;
                    end else begin
                        r_drain_count <= r_drain_count + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // frame memory: write on load, registered read during drain
    always_ff @(posedge i_clk) begin
        if (w_mem_we)
            r_frame[r_load_count[AW-1:0]] <= r_pix;
        r_rd_data <= r_frame[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DRAIN_DIV && w_div_stat.done) begin
            r_inrange <= w_src_ok & w_row_ok;
            r_row     <= ROW_W'(w_div_quo);
            r_col     <= COL_W'(w_rem_col);
            r_last    <= w_drain_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_res_pix    <= '0;
            r_res_row    <= '0;
            r_res_col    <= '0;
            r_res_last   <= 1'b0;
            r_res_status <= STATUS_REFUSED;
        end else if (r_state == S_READ) begin
            r_res_pix    <= r_inrange ? PIX_W'($signed(r_rd_data)) : '0;
            r_res_row    <= r_row;
            r_res_col    <= r_col;
            r_res_last   <= r_last;
            r_res_status <= STATUS_OK;
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_data <= M_DATA_W'({r_res_col, r_res_row, r_res_pix});
            r_out_last <= r_res_last;
            r_out_user <= r_res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == STATUS_REFUSED |-> !o_m_tlast && o_m_tdata == '0)
        else $error("refused fetch carries data or last");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_LOAD_DIV || r_state == S_CENT_DIV ||
                             r_state == S_DRAIN_DIV))
        else $error("divider finished while no state waits for it");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ && r_last |=> r_drain_count == '0 && r_load_count == '0)
        else $error("frame counters not cleared after final pixel");
`endif

endmodule
